// File: rtl/char_lcd_4bit_sequencer_defines.svh
// assertion macros shared by the character-lcd sequencer rtl
`ifndef CHAR_LCD_4BIT_SEQUENCER_DEFINES_SVH
`define CHAR_LCD_4BIT_SEQUENCER_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define CLCD4_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("clcd4 check failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define CLCD4_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("clcd4 check failed");

`endif

// File: rtl/clcd4_pkg.sv
// types and constants for the character-lcd sequencer
package clcd4_pkg;

  typedef enum logic [2:0] {
    CMD_INIT   = 3'd0,
    CMD_INSTR  = 3'd1,
    CMD_DATA   = 3'd2,
    CMD_CURSOR = 3'd3,
    CMD_CLEAR  = 3'd4
  } cmd_t;

  typedef enum logic [2:0] {
    REG_ENABLE_PULSE = 3'd0,
    REG_INSTR_WAIT   = 3'd1,
    REG_DATA_WAIT    = 3'd2,
    REG_POWERUP_WAIT = 3'd3,
    REG_FUNC_SET     = 3'd4,
    REG_DISP_CTRL    = 3'd5,
    REG_ENTRY_MODE   = 3'd6
  } reg_idx_t;

  localparam int unsigned STEP_W = 5;

  localparam logic [15:0] RST_ENABLE_PULSE = 16'd10;
  localparam logic [15:0] RST_INSTR_WAIT   = 16'd2000;
  localparam logic [15:0] RST_DATA_WAIT    = 16'd50;
  localparam logic [15:0] RST_POWERUP_WAIT = 16'd20000;
  localparam logic [7:0]  RST_FUNC_SET     = 8'h28;
  localparam logic [7:0]  RST_DISP_CTRL    = 8'h0C;
  localparam logic [7:0]  RST_ENTRY_MODE   = 8'h06;

  localparam logic [15:0] INIT_WAIT_LONG_US  = 16'd5000;
  localparam logic [15:0] INIT_WAIT_SHORT_US = 16'd200;

  localparam logic [7:0] CLEAR_BYTE     = 8'h01;
  localparam logic [7:0] ROW1_BASE      = 8'h80;
  localparam logic [7:0] ROW2_BASE      = 8'hC0;
  localparam logic [3:0] NIB_WAKE       = 4'h3;
  localparam logic [3:0] NIB_FOUR_BIT   = 4'h2;
  localparam logic [3:0] NIB_EXTRA_WAIT = 4'h1;

  localparam logic [STEP_W-1:0] INIT_LAST_STEP  = 5'd31;
  localparam logic [STEP_W-1:0] INIT_BYTE_FIRST = 5'd11;
  localparam logic [STEP_W-1:0] INIT_BYTE_LAST  = 5'd30;
  localparam logic [STEP_W-1:0] BYTE_LAST_STEP  = 5'd4;
  localparam logic [STEP_W-1:0] CLEAR_LAST_STEP = 5'd5;

  typedef struct packed {
    logic [15:0] enable_pulse_us;
    logic [15:0] instr_wait_us;
    logic [15:0] data_wait_us;
    logic [15:0] powerup_wait_us;
    logic [7:0]  function_set_word;
    logic [7:0]  display_control_word;
    logic [7:0]  entry_mode_word;
  } cfg_t;

  typedef struct packed {
    cmd_t       cmd;
    logic [7:0] byte_val;
  } item_t;

  typedef struct packed {
    logic        rs;
    logic        en;
    logic [3:0]  nib;
    logic [15:0] hold;
    logic        last;
  } ev_t;

endpackage

// File: rtl/clcd4_event.sv
// pin event decoder: one bus event from the current request and its step
module clcd4_event (
  input  clcd4_pkg::cfg_t                     cfg,
  input  clcd4_pkg::item_t                    item,
  input  logic [clcd4_pkg::STEP_W-1:0]        step,
  output clcd4_pkg::ev_t                      ev
);

  logic [clcd4_pkg::STEP_W-1:0] off;
  logic [clcd4_pkg::STEP_W-1:0] ph_full;
  logic [7:0]                   init_byte;
  logic                         rs;

  // one byte as five events: high nibble pulse, low nibble pulse, settle
  function automatic clcd4_pkg::ev_t byte_event(input logic rs_i, input logic [7:0] b,
                                                input logic [2:0] ph,
                                                input logic [15:0] pulse,
                                                input logic [15:0] settle);
    clcd4_pkg::ev_t e;
    e.rs   = rs_i;
    e.en   = (ph == 3'd0) || (ph == 3'd2);
    e.nib  = (ph == 3'd0 || ph == 3'd1) ? b[7:4] : b[3:0];
    e.hold = (ph == 3'd4) ? settle : pulse;
    e.last = 1'b0;
    return e;
  endfunction

  // init instruction bytes: which of the four and the phase within it
  always_comb begin
    off = step - clcd4_pkg::INIT_BYTE_FIRST;
    if (off >= 5'd15) begin
      init_byte = clcd4_pkg::CLEAR_BYTE;
      ph_full   = off - 5'd15;
    end else if (off >= 5'd10) begin
      init_byte = cfg.entry_mode_word;
      ph_full   = off - 5'd10;
    end else if (off >= 5'd5) begin
      init_byte = cfg.display_control_word;
      ph_full   = off - 5'd5;
    end else begin
      init_byte = cfg.function_set_word;
      ph_full   = off;
    end
  end

  assign rs = (item.cmd == clcd4_pkg::CMD_DATA);

  always_comb begin
    ev = '0;
    if (item.cmd == clcd4_pkg::CMD_INIT) begin
      if (step >= clcd4_pkg::INIT_BYTE_FIRST && step <= clcd4_pkg::INIT_BYTE_LAST) begin
        ev = byte_event(1'b0, init_byte, ph_full[2:0], cfg.enable_pulse_us,
                        cfg.instr_wait_us);
      end else begin
        case (step) inside
          5'd0: begin
            ev.hold = cfg.powerup_wait_us;
          end
          5'd1, 5'd4, 5'd7: begin
            ev.en   = 1'b1;
            ev.nib  = clcd4_pkg::NIB_WAKE;
            ev.hold = cfg.enable_pulse_us;
          end
          5'd2, 5'd5, 5'd8: begin
            ev.nib  = clcd4_pkg::NIB_WAKE;
            ev.hold = cfg.enable_pulse_us;
          end
          5'd3: begin
            ev.nib  = clcd4_pkg::NIB_WAKE;
            ev.hold = clcd4_pkg::INIT_WAIT_LONG_US;
          end
          5'd6: begin
            ev.nib  = clcd4_pkg::NIB_WAKE;
            ev.hold = clcd4_pkg::INIT_WAIT_SHORT_US;
          end
          5'd9: begin
            ev.en   = 1'b1;
            ev.nib  = clcd4_pkg::NIB_FOUR_BIT;
            ev.hold = cfg.enable_pulse_us;
          end
          5'd10: begin
            ev.nib  = clcd4_pkg::NIB_FOUR_BIT;
            ev.hold = cfg.enable_pulse_us;
          end
          default: begin
            ev.nib  = clcd4_pkg::NIB_EXTRA_WAIT;
            ev.hold = cfg.instr_wait_us;
          end
        endcase
      end
      ev.last = (step == clcd4_pkg::INIT_LAST_STEP);
    end else begin
      if (step <= clcd4_pkg::BYTE_LAST_STEP) begin
        ev = byte_event(rs, item.byte_val, step[2:0], cfg.enable_pulse_us,
                        rs ? cfg.data_wait_us : cfg.instr_wait_us);
      end else begin
        // extra wait after a clear
        ev.nib  = clcd4_pkg::NIB_EXTRA_WAIT;
        ev.hold = cfg.instr_wait_us;
      end
      ev.last = (item.cmd == clcd4_pkg::CMD_CLEAR) ? (step == clcd4_pkg::CLEAR_LAST_STEP)
                                                   : (step == clcd4_pkg::BYTE_LAST_STEP);
    end
  end

endmodule

// File: rtl/char_lcd_4bit_sequencer.sv
// top level of the 4-bit character-lcd sequencer
//
// usage: a request (in_command with in_byte_value, in_row, in_column) is taken
// on the in_ channel by valid/ready transfer and expands into a run of pin
// events on the out_ channel, one event per transfer, out_last marking the
// final event of the run. each event carries rs, en, the d4..d7 nibble and
// a hold time in microseconds for the pin driver downstream.
// run lengths: init 32 events, instruction, data and set cursor 5, clear 6;
// unused command codes are taken and produce nothing.
// the request is registered first and its first event then moves into the
// output register; events follow one per cycle while out_ready allows, the
// single step counter walking the run.
// the next request is taken in the cycle that the final event of the
// current run moves into the output register, so runs follow back to back.
// when out_ready is low the output register holds its event and the step
// counter stops; the request side then stalls once a run is in progress.
// reset (rst_n low, synchronous) empties the output register, drops any
// run in progress and loads the timing and init registers with defaults.
// the apb port (psel .. prdata) reads and writes those registers at byte
// address 4*index; writes belong between runs.
`include "char_lcd_4bit_sequencer_defines.svh"

module char_lcd_4bit_sequencer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_command,
  input  logic [7:0]  in_byte_value,
  input  logic [1:0]  in_row,
  input  logic [7:0]  in_column,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_reg_select,
  output logic        out_enable,
  output logic [3:0]  out_nibble,
  output logic [15:0] out_hold_us,
  output logic        out_last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  clcd4_pkg::cfg_t              cfg_r;
  clcd4_pkg::item_t             item_r;
  clcd4_pkg::item_t             item_nxt;
  clcd4_pkg::ev_t               ev;
  clcd4_pkg::ev_t               out_r;
  logic [clcd4_pkg::STEP_W-1:0] step_r;
  logic                         busy_r;
  logic                         out_valid_r;
  logic                         adv;
  logic                         in_xfer;
  logic                         cmd_ok;
  logic                         cfg_wr;
  clcd4_pkg::reg_idx_t          reg_idx;

  // configuration registers
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = clcd4_pkg::reg_idx_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enable_pulse_us      <= clcd4_pkg::RST_ENABLE_PULSE;
      cfg_r.instr_wait_us        <= clcd4_pkg::RST_INSTR_WAIT;
      cfg_r.data_wait_us         <= clcd4_pkg::RST_DATA_WAIT;
      cfg_r.powerup_wait_us      <= clcd4_pkg::RST_POWERUP_WAIT;
      cfg_r.function_set_word    <= clcd4_pkg::RST_FUNC_SET;
      cfg_r.display_control_word <= clcd4_pkg::RST_DISP_CTRL;
      cfg_r.entry_mode_word      <= clcd4_pkg::RST_ENTRY_MODE;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        clcd4_pkg::REG_ENABLE_PULSE: cfg_r.enable_pulse_us      <= pwdata[15:0];
        clcd4_pkg::REG_INSTR_WAIT:   cfg_r.instr_wait_us        <= pwdata[15:0];
        clcd4_pkg::REG_DATA_WAIT:    cfg_r.data_wait_us         <= pwdata[15:0];
        clcd4_pkg::REG_POWERUP_WAIT: cfg_r.powerup_wait_us      <= pwdata[15:0];
        clcd4_pkg::REG_FUNC_SET:     cfg_r.function_set_word    <= pwdata[7:0];
        clcd4_pkg::REG_DISP_CTRL:    cfg_r.display_control_word <= pwdata[7:0];
        clcd4_pkg::REG_ENTRY_MODE:   cfg_r.entry_mode_word      <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      clcd4_pkg::REG_ENABLE_PULSE: prdata = {16'd0, cfg_r.enable_pulse_us};
      clcd4_pkg::REG_INSTR_WAIT:   prdata = {16'd0, cfg_r.instr_wait_us};
      clcd4_pkg::REG_DATA_WAIT:    prdata = {16'd0, cfg_r.data_wait_us};
      clcd4_pkg::REG_POWERUP_WAIT: prdata = {16'd0, cfg_r.powerup_wait_us};
      clcd4_pkg::REG_FUNC_SET:     prdata = {24'd0, cfg_r.function_set_word};
      clcd4_pkg::REG_DISP_CTRL:    prdata = {24'd0, cfg_r.display_control_word};
      clcd4_pkg::REG_ENTRY_MODE:   prdata = {24'd0, cfg_r.entry_mode_word};
      default:                     prdata = 32'd0;
    endcase
  end

  // request register: the byte to send is worked out on the way in
  assign cmd_ok = (in_command <= 3'(clcd4_pkg::CMD_CLEAR));

  always_comb begin
    item_nxt.cmd = clcd4_pkg::cmd_t'(in_command);
    case (clcd4_pkg::cmd_t'(in_command)) inside
      clcd4_pkg::CMD_INSTR,
      clcd4_pkg::CMD_DATA:   item_nxt.byte_val = in_byte_value;
      clcd4_pkg::CMD_CURSOR: begin
        if (in_row == 2'd1) begin
          item_nxt.byte_val = clcd4_pkg::ROW1_BASE + in_column - 8'd1;
        end else if (in_row == 2'd2) begin
          item_nxt.byte_val = clcd4_pkg::ROW2_BASE + in_column - 8'd1;
        end else begin
          item_nxt.byte_val = 8'h00;
        end
      end
      clcd4_pkg::CMD_CLEAR:  item_nxt.byte_val = clcd4_pkg::CLEAR_BYTE;
      default:               item_nxt.byte_val = 8'h00;
    endcase
  end

  clcd4_event u_event (
    .cfg  (cfg_r),
    .item (item_r),
    .step (step_r),
    .ev   (ev)
  );

  // output register advances when empty or when its event is taken
  assign adv      = !out_valid_r || out_ready;
  assign in_ready = !busy_r || (adv && ev.last);
  assign in_xfer  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
      step_r      <= '0;
    end else begin
      if (adv) begin
        out_valid_r <= busy_r;
      end
      if (in_xfer) begin
        busy_r <= cmd_ok;
        step_r <= '0;
      end else if (busy_r && adv) begin
        busy_r <= !ev.last;
        step_r <= step_r + 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      item_r <= item_nxt;
    end
    if (busy_r && adv) begin
      out_r <= ev;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_reg_select = out_r.rs;
  assign out_enable     = out_r.en;
  assign out_nibble     = out_r.nib;
  assign out_hold_us    = out_r.hold;
  assign out_last       = out_r.last;

  `CLCD4_ASSERT_NOW(a_take_only_at_run_end, busy_r && in_xfer, adv && ev.last)
  `CLCD4_ASSERT_NEXT(a_run_ends, busy_r && adv && ev.last && !in_xfer, !busy_r)
  `CLCD4_ASSERT_NEXT(a_step_holds_on_stall, busy_r && !adv && !in_xfer, $stable(step_r))
  `CLCD4_ASSERT_NEXT(a_event_kept_on_stall, out_valid_r && !out_ready, out_valid_r)

endmodule

// File: tb/testbench.sv
// testbench for the 4-bit character-lcd sequencer: directed and random requests checked against a predictor
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned QUIET_LIMIT   = 5000;
  localparam int unsigned HOLD_OFF_LEN  = 600;
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned RANDOM_ITEMS  = 80;

  localparam logic [2:0] CMD_FIRST_UNUSED = 3'd5;
  localparam logic [2:0] CMD_LAST_CODE    = 3'd7;
  localparam logic [1:0] ROW_TOP          = 2'd1;
  localparam logic [1:0] ROW_BOTTOM       = 2'd2;

  localparam logic [15:0] WAKE_WAIT_LONG  = 16'd5000;
  localparam logic [15:0] WAKE_WAIT_SHORT = 16'd200;
  localparam logic [7:0]  CLEAR_INSTR     = 8'h01;
  localparam logic [7:0]  DDRAM_ROW_TOP   = 8'h80;
  localparam logic [7:0]  DDRAM_ROW_BOT   = 8'hC0;
  localparam logic [3:0]  WAKE_NIB        = 4'h3;
  localparam logic [3:0]  FOUR_BIT_NIB    = 4'h2;
  localparam logic [3:0]  TAIL_NIB        = 4'h1;

  class lcd_event_scoreboard;
    clcd4_pkg::cfg_t regs;
    clcd4_pkg::ev_t  pending_events[$];
    int unsigned     mismatches;

    function new();
      regs.enable_pulse_us      = 16'd10;
      regs.instr_wait_us        = 16'd2000;
      regs.data_wait_us         = 16'd50;
      regs.powerup_wait_us      = 16'd20000;
      regs.function_set_word    = 8'h28;
      regs.display_control_word = 8'h0C;
      regs.entry_mode_word      = 8'h06;
      mismatches = 0;
    endfunction

    function void write_reg(clcd4_pkg::reg_idx_t idx, logic [31:0] value);
      case (idx)
        clcd4_pkg::REG_ENABLE_PULSE: regs.enable_pulse_us      = value[15:0];
        clcd4_pkg::REG_INSTR_WAIT:   regs.instr_wait_us        = value[15:0];
        clcd4_pkg::REG_DATA_WAIT:    regs.data_wait_us         = value[15:0];
        clcd4_pkg::REG_POWERUP_WAIT: regs.powerup_wait_us      = value[15:0];
        clcd4_pkg::REG_FUNC_SET:     regs.function_set_word    = value[7:0];
        clcd4_pkg::REG_DISP_CTRL:    regs.display_control_word = value[7:0];
        clcd4_pkg::REG_ENTRY_MODE:   regs.entry_mode_word      = value[7:0];
        default: ;
      endcase
    endfunction

    function void push_event(logic rs, logic en, logic [3:0] nib, logic [15:0] hold);
      clcd4_pkg::ev_t e;
      e.rs   = rs;
      e.en   = en;
      e.nib  = nib;
      e.hold = hold;
      e.last = 1'b0;
      pending_events.push_back(e);
    endfunction

    function void push_nibble(logic rs, logic [3:0] nib);
      push_event(rs, 1'b1, nib, regs.enable_pulse_us);
      push_event(rs, 1'b0, nib, regs.enable_pulse_us);
    endfunction

    function void push_byte(logic rs, logic [7:0] value);
      push_nibble(rs, value[7:4]);
      push_nibble(rs, value[3:0]);
      // settle keeps the low nibble on the bus
      push_event(rs, 1'b0, value[3:0], rs ? regs.data_wait_us : regs.instr_wait_us);
    endfunction

    // expands one accepted request into its run of pin events
    function void note_request(logic [2:0] cmd, logic [7:0] value, logic [1:0] row,
                               logic [7:0] column);
      int unsigned before_count;
      logic [7:0]  ddram_addr;
      before_count = pending_events.size();
      case (cmd)
        clcd4_pkg::CMD_INIT: begin
          push_event(1'b0, 1'b0, 4'h0, regs.powerup_wait_us);
          push_nibble(1'b0, WAKE_NIB);
          push_event(1'b0, 1'b0, WAKE_NIB, WAKE_WAIT_LONG);
          push_nibble(1'b0, WAKE_NIB);
          push_event(1'b0, 1'b0, WAKE_NIB, WAKE_WAIT_SHORT);
          push_nibble(1'b0, WAKE_NIB);
          push_nibble(1'b0, FOUR_BIT_NIB);
          push_byte(1'b0, regs.function_set_word);
          push_byte(1'b0, regs.display_control_word);
          push_byte(1'b0, regs.entry_mode_word);
          push_byte(1'b0, CLEAR_INSTR);
          push_event(1'b0, 1'b0, TAIL_NIB, regs.instr_wait_us);
        end
        clcd4_pkg::CMD_INSTR: push_byte(1'b0, value);
        clcd4_pkg::CMD_DATA:  push_byte(1'b1, value);
        clcd4_pkg::CMD_CURSOR: begin
          if (row == ROW_TOP)
            ddram_addr = DDRAM_ROW_TOP + column - 8'd1;
          else if (row == ROW_BOTTOM)
            ddram_addr = DDRAM_ROW_BOT + column - 8'd1;
          else
            ddram_addr = 8'h00;
          push_byte(1'b0, ddram_addr);
        end
        clcd4_pkg::CMD_CLEAR: begin
          push_byte(1'b0, CLEAR_INSTR);
          push_event(1'b0, 1'b0, TAIL_NIB, regs.instr_wait_us);
        end
        default: ;
      endcase
      if (pending_events.size() > before_count)
        pending_events[pending_events.size() - 1].last = 1'b1;
    endfunction

    function void check_event(clcd4_pkg::ev_t got);
      clcd4_pkg::ev_t want;
      if (pending_events.size() == 0) begin
        $error("pin event with none outstanding: rs=%0d en=%0d nibble=%h hold=%0d last=%0d",
               got.rs, got.en, got.nib, got.hold, got.last);
        mismatches++;
        return;
      end
      want = pending_events.pop_front();
      if (got.rs !== want.rs) begin
        $error("reg_select: expected %0d, got %0d", want.rs, got.rs);
        mismatches++;
      end
      if (got.en !== want.en) begin
        $error("enable: expected %0d, got %0d", want.en, got.en);
        mismatches++;
      end
      if (got.nib !== want.nib) begin
        $error("nibble: expected %h, got %h", want.nib, got.nib);
        mismatches++;
      end
      if (got.hold !== want.hold) begin
        $error("hold_us: expected %0d, got %0d", want.hold, got.hold);
        mismatches++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0d, got %0d", want.last, got.last);
        mismatches++;
      end
    endfunction

    function int unsigned outstanding();
      return pending_events.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [2:0]  in_command;
  logic [7:0]  in_byte_value;
  logic [1:0]  in_row;
  logic [7:0]  in_column;
  logic        out_valid;
  logic        out_ready;
  logic        out_reg_select;
  logic        out_enable;
  logic [3:0]  out_nibble;
  logic [15:0] out_hold_us;
  logic        out_last;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  lcd_event_scoreboard sb;
  bit no_idle;
  bit hold_receiver;

  char_lcd_4bit_sequencer i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_command     (in_command),
    .in_byte_value  (in_byte_value),
    .in_row         (in_row),
    .in_column      (in_column),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_reg_select (out_reg_select),
    .out_enable     (out_enable),
    .out_nibble     (out_nibble),
    .out_hold_us    (out_hold_us),
    .out_last       (out_last),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (no_idle)
      return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55)
      return 0;
    if (roll < 90)
      return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  task automatic send_request(input logic [2:0] cmd, input logic [7:0] value,
                              input logic [1:0] row, input logic [7:0] column);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_command    <= cmd;
    in_byte_value <= value;
    in_row        <= row;
    in_column     <= column;
    in_valid      <= 1'b1;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_random_request();
    int unsigned roll;
    logic [2:0]  cmd;
    logic [1:0]  row;
    roll = $urandom_range(0, 99);
    if (roll < 8)
      cmd = clcd4_pkg::CMD_INIT;
    else if (roll < 30)
      cmd = clcd4_pkg::CMD_INSTR;
    else if (roll < 58)
      cmd = clcd4_pkg::CMD_DATA;
    else if (roll < 84)
      cmd = clcd4_pkg::CMD_CURSOR;
    else if (roll < 93)
      cmd = clcd4_pkg::CMD_CLEAR;
    else
      cmd = 3'($urandom_range(int'(CMD_FIRST_UNUSED), int'(CMD_LAST_CODE)));
    if ($urandom_range(0, 3) == 0)
      row = 2'($urandom);
    else
      row = $urandom_range(0, 1) ? ROW_TOP : ROW_BOTTOM;
    send_request(cmd, 8'($urandom), row, 8'($urandom));
  endtask

  task automatic run_random(input int unsigned count, input bit with_hold_off);
    for (int unsigned i = 0; i < count; i++) begin
      if (i % 20 == 0)
        no_idle = ($urandom_range(0, 3) == 0);
      // stall the event side while requests keep coming
      if (with_hold_off && i == 10) begin
        hold_receiver = 1'b1;
        no_idle = 1'b1;
      end
      send_random_request();
    end
    no_idle = 1'b0;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apb_write(input clcd4_pkg::reg_idx_t idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.write_reg(idx, value);
    @(posedge clk);
  endtask

  task automatic write_all(input clcd4_pkg::cfg_t c);
    apb_write(clcd4_pkg::REG_ENABLE_PULSE, {16'd0, c.enable_pulse_us});
    apb_write(clcd4_pkg::REG_INSTR_WAIT,   {16'd0, c.instr_wait_us});
    apb_write(clcd4_pkg::REG_DATA_WAIT,    {16'd0, c.data_wait_us});
    apb_write(clcd4_pkg::REG_POWERUP_WAIT, {16'd0, c.powerup_wait_us});
    apb_write(clcd4_pkg::REG_FUNC_SET,     {24'd0, c.function_set_word});
    apb_write(clcd4_pkg::REG_DISP_CTRL,    {24'd0, c.display_control_word});
    apb_write(clcd4_pkg::REG_ENTRY_MODE,   {24'd0, c.entry_mode_word});
  endtask

  function automatic clcd4_pkg::cfg_t random_cfg();
    clcd4_pkg::cfg_t c;
    c.enable_pulse_us      = 16'($urandom);
    c.instr_wait_us        = 16'($urandom);
    c.data_wait_us         = 16'($urandom);
    c.powerup_wait_us      = 16'($urandom);
    c.function_set_word    = 8'($urandom);
    c.display_control_word = 8'($urandom);
    c.entry_mode_word      = 8'($urandom);
    return c;
  endfunction

  // transfer monitor: both channels sampled at the edge
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready)
      sb.note_request(in_command, in_byte_value, in_row, in_column);
    if (rst_n && out_valid && out_ready)
      sb.check_event({out_reg_select, out_enable, out_nibble, out_hold_us, out_last});
  end

  initial begin
    int unsigned stall;
    out_ready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_receiver) begin
        out_ready <= 1'b0;
        repeat (HOLD_OFF_LEN) @(posedge clk);
        hold_receiver = 1'b0;
      end else begin
        stall = pick_gap();
        if (stall != 0) begin
          out_ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  end

  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable && pready))
        quiet = 0;
      else
        quiet++;
    end
    $display("testbench: errors");
    $finish;
  end

  initial begin
    sb = new();
    no_idle       = 1'b0;
    hold_receiver = 1'b0;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_command    = clcd4_pkg::CMD_INIT;
    in_byte_value = 8'h00;
    in_row        = 2'd0;
    in_column     = 8'h00;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed run at the reset settings
    send_request(clcd4_pkg::CMD_INIT,   8'h00, 2'd0, 8'h00);
    send_request(clcd4_pkg::CMD_INSTR,  8'h00, 2'd0, 8'h00);
    send_request(clcd4_pkg::CMD_INSTR,  8'hFF, 2'd3, 8'hFF);
    send_request(clcd4_pkg::CMD_DATA,   8'h00, 2'd0, 8'h00);
    send_request(clcd4_pkg::CMD_DATA,   8'hFF, 2'd3, 8'hFF);
    send_request(clcd4_pkg::CMD_DATA,   8'hA5, 2'd1, 8'h5A);
    send_request(clcd4_pkg::CMD_CURSOR, 8'h00, ROW_TOP, 8'd1);
    // column zero wraps below the row base
    send_request(clcd4_pkg::CMD_CURSOR, 8'h00, ROW_TOP, 8'd0);
    send_request(clcd4_pkg::CMD_CURSOR, 8'hFF, ROW_TOP, 8'd255);
    send_request(clcd4_pkg::CMD_CURSOR, 8'h00, ROW_BOTTOM, 8'd1);
    send_request(clcd4_pkg::CMD_CURSOR, 8'h00, ROW_BOTTOM, 8'd255);
    send_request(clcd4_pkg::CMD_CURSOR, 8'h00, ROW_BOTTOM, 8'h41);
    send_request(clcd4_pkg::CMD_CURSOR, 8'h33, 2'd0, 8'd7);
    send_request(clcd4_pkg::CMD_CURSOR, 8'h33, 2'd3, 8'd7);
    send_request(clcd4_pkg::CMD_CLEAR,  8'hFF, 2'd3, 8'hFF);
    send_request(CMD_FIRST_UNUSED, 8'hFF, 2'd3, 8'hFF);
    send_request(CMD_LAST_CODE, 8'h00, 2'd0, 8'h00);
    send_request(clcd4_pkg::CMD_INSTR,  8'h5A, 2'd2, 8'h00);
    settle();

    write_all('0);
    send_request(clcd4_pkg::CMD_INIT, 8'h00, 2'd0, 8'h00);
    run_random(RANDOM_ITEMS, 1'b0);
    settle();

    write_all('{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF});
    send_request(clcd4_pkg::CMD_INIT, 8'h00, 2'd0, 8'h00);
    run_random(RANDOM_ITEMS, 1'b0);
    settle();

    write_all(random_cfg());
    run_random(RANDOM_ITEMS, 1'b1);
    settle();

    write_all(random_cfg());
    run_random(RANDOM_ITEMS, 1'b0);
    settle();

    write_all(random_cfg());
    run_random(RANDOM_ITEMS, 1'b0);
    settle();

    if (sb.mismatches == 0 && sb.outstanding() == 0)
      $display("testbench: clean");
    else
      $display("testbench: errors");
    $finish;
  end

endmodule

// File: files.f
+incdir+rtl
rtl/clcd4_pkg.sv
rtl/clcd4_event.sv
rtl/char_lcd_4bit_sequencer.sv
tb/testbench.sv
